/* src/sahm_pkg.sv */
// ----------------------------------------------------------------------------
// sahm_pkg
// Shared types and constants for the stereo audio health monitor.
// ----------------------------------------------------------------------------
package sahm_pkg;

  // Default parameter values
  localparam int COUNT_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF   = 22;

  // Float32 field widths and marker values
  localparam int               MAG_W     = 31;
  localparam logic [MAG_W-1:0] INF_MAG   = 31'h7F80_0000;
  localparam logic [MAG_W-1:0] EIGHT_MAG = 31'h4100_0000;

  // Sum of squares: 63 bits, 32 fraction bits; one square never exceeds 2^38
  localparam int SUM_W = 63;
  localparam int SQ_W  = 39;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_SILENCE_LIMIT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERRANGE_LIMIT = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GLITCH_LIMIT    = 8'd2;

  // Register reset values
  localparam logic [MAG_W-1:0] SILENCE_LIMIT_RST   = 31'd925353388;
  localparam logic [MAG_W-1:0] OVERRANGE_LIMIT_RST = 31'd1065353216;
  localparam int               GLITCH_LIMIT_RST    = 419430;

  // Classification of one sample
  typedef struct packed {
    logic             is_nan;
    logic             is_inf;
    logic             is_over;
    logic             is_silent;
    logic [MAG_W-1:0] mag;
  } sahm_class_t;

endpackage

/* src/sahm_if.sv */
// ----------------------------------------------------------------------------
// sahm_if
// Channel interfaces: sample pairs in, reports out, register writes.
// ----------------------------------------------------------------------------
interface sahm_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_bits;
  logic [31:0] right_bits;
  logic        end_of_capture;

  modport source (output valid, left_bits, right_bits, end_of_capture, input ready);
  modport sink   (input valid, left_bits, right_bits, end_of_capture, output ready);
endinterface

interface sahm_report_if #(
  parameter int COUNT_WIDTH = sahm_pkg::COUNT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic [COUNT_WIDTH-1:0]        nan_count;
  logic [COUNT_WIDTH-1:0]        infinite_count;
  logic [COUNT_WIDTH-1:0]        overrange_count;
  logic [COUNT_WIDTH-1:0]        silent_count;
  logic [COUNT_WIDTH-1:0]        longest_silence;
  logic [sahm_pkg::MAG_W-1:0]    peak_magnitude;
  logic [sahm_pkg::SUM_W-1:0]    sum_squares;
  logic [COUNT_WIDTH-1:0]        glitch_total;
  logic                          report_last;

  modport source (output valid, channel, nan_count, infinite_count, overrange_count,
                  silent_count, longest_silence, peak_magnitude, sum_squares,
                  glitch_total, report_last, input ready);
  modport sink   (input valid, channel, nan_count, infinite_count, overrange_count,
                  silent_count, longest_silence, peak_magnitude, sum_squares,
                  glitch_total, report_last, output ready);
endinterface

interface sahm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sahm_pkg::CFG_INDEX_W-1:0]    index;
  logic [sahm_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/sahm_classify.sv */
// ----------------------------------------------------------------------------
// sahm_classify
// Classifies one float32 sample and converts it to signed fixed point with
// four integer bits, saturating at plus and minus eight.
// ----------------------------------------------------------------------------
module sahm_classify
  import sahm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [31:0]              sample_bits,
  input  logic [MAG_W-1:0]         silence_limit,
  input  logic [MAG_W-1:0]         overrange_limit,
  output sahm_class_t              cls,
  output logic [FRAC_BITS+3:0]     abs_fixed,
  output logic signed [FRAC_BITS+3:0] fixed
);

  localparam int FW = FRAC_BITS + 4;
  localparam logic [FW-1:0] POS_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic [FW-1:0] NEG_MAG = {1'b1, {(FW-1){1'b0}}};

  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic [7:0]        expo;
  logic [23:0]       sig;
  logic signed [9:0] amt;
  logic [9:0]        amt_right;
  logic [31:0]       shifted;

  assign mag = sample_bits[30:0];
  assign neg = sample_bits[31];

  // Classify against the fixed markers and the register limits
  always_comb begin
    cls.mag       = mag;
    cls.is_nan    = mag > INF_MAG;
    cls.is_inf    = mag == INF_MAG;
    cls.is_over   = !cls.is_nan && (mag > overrange_limit);
    cls.is_silent = !cls.is_nan && (mag < silence_limit);
  end

  // Align the significand to the fixed-point grid, truncating toward zero
  always_comb begin
    expo      = (mag[30:23] == 8'd0) ? 8'd1 : mag[30:23];
    sig       = {(mag[30:23] != 8'd0), mag[22:0]};
    amt       = $signed({2'b00, expo}) + 10'(FRAC_BITS) - 10'sd150;
    amt_right = 10'(-amt);
    if (amt >= 0) begin
      shifted = {8'b0, sig} << $unsigned(amt);
    end else begin
      shifted = {8'b0, sig} >> amt_right;
    end
  end

  // Saturate, drop NaN, then apply the sign
  always_comb begin
    if (cls.is_nan) begin
      abs_fixed = '0;
    end else if (mag >= EIGHT_MAG) begin
      abs_fixed = neg ? NEG_MAG : POS_MAX;
    end else begin
      abs_fixed = {1'b0, shifted[FW-2:0]};
    end
    fixed = neg ? -$signed(abs_fixed) : $signed(abs_fixed);
  end

endmodule

/* src/stereo_audio_health_monitor.sv */
// ----------------------------------------------------------------------------
// stereo_audio_health_monitor
// Per-channel health statistics over a stereo float32 sample stream.
// ----------------------------------------------------------------------------
// One sample pair is taken every cycle while the input is not stalled. Each
// pair passes an input register, a classify and fixed-point conversion stage
// and a squaring stage, and is then folded into the running statistics.
// A pair marked end_of_capture produces two report beats, left then right,
// from a report buffer, and clears the statistics; further pairs keep flowing
// while the reports wait. A second end of capture that reaches the statistics
// stage while the previous right report has not yet gone holds the pipeline
// until it leaves, so the input stalls only when two report runs overlap and
// the report side is slow. Register writes take effect in the next cycle.
module stereo_audio_health_monitor
  import sahm_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  sahm_sample_if.sink          samples,
  sahm_report_if.source        reports,
  sahm_cfg_if.sink             cfg
);

  localparam int FW       = FRAC_BITS + 4;
  localparam int LIM_W    = FRAC_BITS + 3;
  localparam int SQ_SHIFT = 2 * FRAC_BITS - 32;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c,
                                                     input logic en);
    return (en && (c != '1)) ? c + 1'b1 : c;
  endfunction

  // Registers
  logic [MAG_W-1:0] silence_limit;
  logic [MAG_W-1:0] overrange_limit;
  logic [LIM_W-1:0] glitch_limit;

  // Pipeline
  logic              a_valid, b_valid, c_valid;
  logic [31:0]       a_bits [2];
  logic              a_last, b_last, c_last;
  sahm_class_t       cls_in [2];
  logic [FW-1:0]     abs_in [2];
  logic signed [FW-1:0] fix_in [2];
  sahm_class_t       b_cls [2];
  logic [FW-1:0]     b_abs [2];
  logic signed [FW-1:0] b_fix [2];
  sahm_class_t       c_cls [2];
  logic signed [FW-1:0] c_fix [2];
  logic [SQ_W-1:0]   c_sq [2];
  logic [2*FW-1:0]   prod [2];

  logic a_move, b_move, c_go;
  logic a_free, b_free, c_free;

  // Statistics
  logic [COUNT_WIDTH-1:0] nan_cnt [2], nan_cnt_next [2];
  logic [COUNT_WIDTH-1:0] inf_cnt [2], inf_cnt_next [2];
  logic [COUNT_WIDTH-1:0] over_cnt [2], over_cnt_next [2];
  logic [COUNT_WIDTH-1:0] sil_cnt [2], sil_cnt_next [2];
  logic [MAG_W-1:0]       peak [2], peak_next [2];
  logic [SUM_W-1:0]       sum_sq [2], sum_sq_next [2];
  logic [SUM_W:0]         sum_wide [2];
  logic [COUNT_WIDTH-1:0] run_len, run_len_next;
  logic [COUNT_WIDTH-1:0] longest, longest_next, longest_report;
  logic [COUNT_WIDTH-1:0] glitch_cnt, glitch_cnt_next;
  logic signed [FW-1:0]   prev_fix [2];
  logic                   have_prev;
  logic signed [FW:0]     diff [2];
  logic [FW:0]            diff_abs [2];
  logic                   jump;

  // Report buffer
  logic                   rep_valid;
  logic                   rep_phase;
  logic                   rep_pop;
  logic [COUNT_WIDTH-1:0] rep_nan [2], rep_inf [2], rep_over [2], rep_sil [2];
  logic [MAG_W-1:0]       rep_peak [2];
  logic [SUM_W-1:0]       rep_sum [2];
  logic [COUNT_WIDTH-1:0] rep_longest;
  logic [COUNT_WIDTH-1:0] rep_glitch;

  // Register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_limit   <= SILENCE_LIMIT_RST;
      overrange_limit <= OVERRANGE_LIMIT_RST;
      glitch_limit    <= LIM_W'(GLITCH_LIMIT_RST);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SILENCE_LIMIT:   silence_limit   <= cfg.data[MAG_W-1:0];
        REG_OVERRANGE_LIMIT: overrange_limit <= cfg.data[MAG_W-1:0];
        REG_GLITCH_LIMIT:    glitch_limit    <= cfg.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall chain: a final pair waits only for a free report buffer
  always_comb begin
    rep_pop = rep_valid && reports.ready;
    c_go    = c_valid && (!c_last || !rep_valid || (rep_pop && rep_phase));
    c_free  = !c_valid || c_go;
    b_move  = b_valid && c_free;
    b_free  = !b_valid || b_move;
    a_move  = a_valid && b_free;
    a_free  = !a_valid || a_move;
  end

  assign samples.ready = a_free;

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= samples.valid;
      if (b_free) b_valid <= a_valid;
      if (c_free) c_valid <= b_valid;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (samples.valid && a_free) begin
      a_bits[0] <= samples.left_bits;
      a_bits[1] <= samples.right_bits;
      a_last    <= samples.end_of_capture;
    end
  end

  // Classify and convert both channels
  for (genvar ch = 0; ch < 2; ch++) begin : g_cls
    sahm_classify #(
      .FRAC_BITS (FRAC_BITS)
    ) u_classify (
      .sample_bits     (a_bits[ch]),
      .silence_limit   (silence_limit),
      .overrange_limit (overrange_limit),
      .cls             (cls_in[ch]),
      .abs_fixed       (abs_in[ch]),
      .fixed           (fix_in[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_cls  <= cls_in;
      b_abs  <= abs_in;
      b_fix  <= fix_in;
      b_last <= a_last;
    end
  end

  // Square and truncate to 32 fraction bits
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      prod[ch] = b_abs[ch] * b_abs[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      c_cls  <= b_cls;
      c_fix  <= b_fix;
      c_last <= b_last;
      for (int ch = 0; ch < 2; ch++) begin
        c_sq[ch] <= SQ_W'(prod[ch] >> SQ_SHIFT);
      end
    end
  end

  // Fold one pair into the statistics
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      nan_cnt_next[ch]  = sat_inc(nan_cnt[ch], c_cls[ch].is_nan);
      inf_cnt_next[ch]  = sat_inc(inf_cnt[ch], c_cls[ch].is_inf);
      over_cnt_next[ch] = sat_inc(over_cnt[ch], c_cls[ch].is_over);
      sil_cnt_next[ch]  = sat_inc(sil_cnt[ch], c_cls[ch].is_silent);
      peak_next[ch]     = (!c_cls[ch].is_nan && (c_cls[ch].mag > peak[ch])) ?
                          c_cls[ch].mag : peak[ch];
      sum_wide[ch]      = {1'b0, sum_sq[ch]} + (SUM_W + 1)'(c_sq[ch]);
      sum_sq_next[ch]   = sum_wide[ch][SUM_W] ? {SUM_W{1'b1}} : sum_wide[ch][SUM_W-1:0];
      diff[ch]          = (FW + 1)'(c_fix[ch]) - (FW + 1)'(prev_fix[ch]);
      diff_abs[ch]      = (diff[ch] < 0) ? $unsigned(-diff[ch]) : $unsigned(diff[ch]);
    end

    // Left silent run: close the run on any sample that is not silent
    if (c_cls[0].is_silent) begin
      run_len_next = sat_inc(run_len, 1'b1);
      longest_next = longest;
    end else begin
      run_len_next = '0;
      longest_next = (run_len > longest) ? run_len : longest;
    end
    longest_report = (run_len_next > longest_next) ? run_len_next : longest_next;

    jump = have_prev && ((diff_abs[0] > (FW + 1)'(glitch_limit)) ||
                         (diff_abs[1] > (FW + 1)'(glitch_limit)));
    glitch_cnt_next = sat_inc(glitch_cnt, jump);
  end

  // Statistics state: clear once a final pair has been folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < 2; ch++) begin
        nan_cnt[ch]  <= '0;
        inf_cnt[ch]  <= '0;
        over_cnt[ch] <= '0;
        sil_cnt[ch]  <= '0;
        peak[ch]     <= '0;
        sum_sq[ch]   <= '0;
        prev_fix[ch] <= '0;
      end
      run_len    <= '0;
      longest    <= '0;
      glitch_cnt <= '0;
      have_prev  <= 1'b0;
    end else if (c_go) begin
      for (int ch = 0; ch < 2; ch++) begin
        nan_cnt[ch]  <= c_last ? '0 : nan_cnt_next[ch];
        inf_cnt[ch]  <= c_last ? '0 : inf_cnt_next[ch];
        over_cnt[ch] <= c_last ? '0 : over_cnt_next[ch];
        sil_cnt[ch]  <= c_last ? '0 : sil_cnt_next[ch];
        peak[ch]     <= c_last ? '0 : peak_next[ch];
        sum_sq[ch]   <= c_last ? '0 : sum_sq_next[ch];
        prev_fix[ch] <= c_last ? '0 : c_fix[ch];
      end
      run_len    <= c_last ? '0 : run_len_next;
      longest    <= c_last ? '0 : longest_next;
      glitch_cnt <= c_last ? '0 : glitch_cnt_next;
      have_prev  <= !c_last;
    end
  end

  // Report buffer control: left beat, then right beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
      rep_phase <= 1'b0;
    end else if (c_go && c_last) begin
      rep_valid <= 1'b1;
      rep_phase <= 1'b0;
    end else if (rep_pop) begin
      rep_valid <= !rep_phase;
      rep_phase <= !rep_phase;
    end
  end

  // Snapshot the final statistics
  always_ff @(posedge clk) begin
    if (c_go && c_last) begin
      rep_nan     <= nan_cnt_next;
      rep_inf     <= inf_cnt_next;
      rep_over    <= over_cnt_next;
      rep_sil     <= sil_cnt_next;
      rep_peak    <= peak_next;
      rep_sum     <= sum_sq_next;
      rep_longest <= longest_report;
      rep_glitch  <= glitch_cnt_next;
    end
  end

  // Drive the report beat
  always_comb begin
    reports.valid           = rep_valid;
    reports.channel         = rep_phase;
    reports.nan_count       = rep_nan[rep_phase];
    reports.infinite_count  = rep_inf[rep_phase];
    reports.overrange_count = rep_over[rep_phase];
    reports.silent_count    = rep_sil[rep_phase];
    reports.longest_silence = rep_phase ? '0 : rep_longest;
    reports.peak_magnitude  = rep_peak[rep_phase];
    reports.sum_squares     = rep_sum[rep_phase];
    reports.glitch_total    = rep_glitch;
    reports.report_last     = rep_phase;
  end

`ifndef SYNTHESIS
  // A final pair never overwrites a report run that has not finished
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    c_go && c_last |-> !rep_valid || (rep_pop && rep_phase))
    else $error("report buffer overwritten");

  // After a final pair the statistics restart from nothing
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    c_go && c_last |=> !have_prev && glitch_cnt == '0 && run_len == '0)
    else $error("statistics not cleared after end of capture");

  // The right beat leaving empties the buffer unless a new run is loaded
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    rep_pop && rep_phase && !(c_go && c_last) |=> !rep_valid)
    else $error("report buffer held after right report");

  // The right report carries no silent run
  a_right_no_run: assert property (@(posedge clk) disable iff (rst)
    rep_valid && rep_phase |-> reports.longest_silence == '0)
    else $error("longest silence on right report");

  // The input stalls only when the pipeline is full up to a held final pair
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> a_valid && b_valid && c_valid && c_last && rep_valid)
    else $error("input stalled without cause");
`endif

endmodule
